@@ rtl/boa_pkg.sv @@
// Shared types, opcodes and status codes for the bounded ordered array unit.
// No dependencies; imported by the cell and the top level.
package boa_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned ITEM_BITS_DEF = 32;
  localparam int unsigned LIMIT_W       = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_INSERT    = 3'd1;
  localparam logic [2:0] OP_REMOVE    = 3'd2;
  localparam logic [2:0] OP_OVERWRITE = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_FIND      = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] COP_NONE   = 2'd0;
  localparam logic [1:0] COP_WRITE  = 2'd1;
  localparam logic [1:0] COP_INSERT = 2'd2;
  localparam logic [1:0] COP_REMOVE = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic [31:0] read_value;
    logic [6:0]  item_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0] cop;
    logic       find;
  } cell_ctl_t;

endpackage

@@ rtl/boa_cell.sv @@
// One array cell: holds one item, shifts with its neighbours and ripples the
// first-match carry towards the top of the chain. Depends on boa_pkg.
module boa_cell #(
  parameter int unsigned DEPTH     = boa_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_BITS = boa_pkg::ITEM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic [$clog2(DEPTH)-1:0]     cell_idx_i,
  input  boa_pkg::cell_ctl_t           ctl_i,
  input  logic [$clog2(DEPTH)-1:0]     pos_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  logic [ITEM_BITS-1:0]         value_i,
  input  logic [ITEM_BITS-1:0]         lower_i,
  input  logic [ITEM_BITS-1:0]         upper_i,
  output logic [ITEM_BITS-1:0]         entry_o,
  input  logic                         hit_i,
  input  logic [$clog2(DEPTH)-1:0]     hit_idx_i,
  input  logic [ITEM_BITS-1:0]         hit_data_i,
  output logic                         hit_o,
  output logic [$clog2(DEPTH)-1:0]     hit_idx_o,
  output logic [ITEM_BITS-1:0]         hit_data_o
);
  import boa_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [ITEM_BITS-1:0] entry_q, entry_d;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [ITEM_BITS-1:0] hit_data_q;
  logic [CNT_W-1:0]     idx_w, idx_p1;
  logic                 eq_pos, gt_pos, lt_cnt, le_cnt, own_hit;

  assign idx_w  = CNT_W'(cell_idx_i);
  assign idx_p1 = idx_w + CNT_W'(1);
  assign eq_pos = (cell_idx_i == pos_i);
  assign gt_pos = (cell_idx_i > pos_i);
  assign lt_cnt = (idx_w < count_i);
  assign le_cnt = (idx_w <= count_i);

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.cop)
      COP_WRITE: begin
        if (eq_pos) entry_d = value_i;
      end
      COP_INSERT: begin
        if (eq_pos) entry_d = value_i;
        else if (gt_pos && le_cnt) entry_d = lower_i;
      end
      COP_REMOVE: begin
        if ((eq_pos || gt_pos) && (idx_p1 < count_i)) entry_d = upper_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  assign own_hit = ctl_i.find ? (lt_cnt && (entry_q == value_i)) : eq_pos;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (hit_i) begin
      hit_q      <= 1'b1;
      hit_idx_q  <= hit_idx_i;
      hit_data_q <= hit_data_i;
    end else begin
      hit_q      <= own_hit;
      hit_idx_q  <= cell_idx_i;
      hit_data_q <= entry_q;
    end
  end

  assign entry_o    = entry_q;
  assign hit_o      = hit_q;
  assign hit_idx_o  = hit_idx_q;
  assign hit_data_o = hit_data_q;

endmodule

@@ rtl/bounded_ordered_array_unit.sv @@
// Top level of the bounded ordered array: command decode, item count, limit
// register and the chain of boa_cell instances. Depends on boa_pkg, boa_cell.
//
//   channel  | handshake                 | word
//   ---------+---------------------------+----------------------------
//   command  | start / busy              | req_i  (boa_pkg::req_t)
//   result   | done_o strobe, no stall   | rsp_o  (boa_pkg::rsp_t)
//   config   | cfg_valid_i / cfg_ready_o | cfg_data_i (item limit)
//
// Append, insert, remove, overwrite, clear and failed index checks: result in the
// cycle after start; the next word may follow at once.
// Read and find: the sweep counter runs down from DEPTH while the match carry
// ripples one cell per cycle up the chain; busy holds until the result.
// Reset empties the array and sets the item limit to 64; cell contents are
// undefined until written. The receiver cannot stall results.
module bounded_ordered_array_unit #(
  parameter int unsigned DEPTH     = boa_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_BITS = boa_pkg::ITEM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  boa_pkg::req_t                req_i,
  output logic                         done_o,
  output boa_pkg::rsp_t                rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [boa_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import boa_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SWEEP = 1'b1;

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     sw_cnt_q, sw_cnt_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [LIMIT_W-1:0]   limit_q;
  cell_ctl_t            ctl_q, ctl_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     qcnt_q;
  logic [ITEM_BITS-1:0] val_q, val_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 accept;
  logic [CMP_W-1:0]     pos_w, cnt_w, lim_w, eff_lim;
  logic                 full;

  logic [ITEM_BITS-1:0] entry [DEPTH];
  logic                 hit   [DEPTH];
  logic [IDX_W-1:0]     hit_idx  [DEPTH];
  logic [ITEM_BITS-1:0] hit_data [DEPTH];

  assign accept      = start && !busy;
  assign busy        = (state_q == S_SWEEP);
  assign cfg_ready_o = 1'b1;

  assign pos_w   = CMP_W'(req_i.position);
  assign cnt_w   = CMP_W'(count_q);
  assign lim_w   = CMP_W'(limit_q);
  assign eff_lim = (lim_w > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_w;
  assign full    = (cnt_w >= eff_lim);

  always_comb begin
    state_d  = state_q;
    sw_cnt_d = sw_cnt_q;
    count_d  = count_q;
    ctl_d    = '{cop: COP_NONE, find: ctl_q.find};
    pos_d    = pos_q;
    val_d    = val_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d  = ITEM_BITS'(req_i.item_value);
          pos_d  = IDX_W'(req_i.position);
          done_d = 1'b1;
          rsp_d  = '{status: ST_OK, found_position: '0, read_value: '0,
                     item_count: '0};
          unique case (req_i.opcode)
            OP_APPEND: begin
              if (full) rsp_d.status = ST_FULL;
              else begin
                ctl_d.cop = COP_WRITE;
                pos_d     = IDX_W'(count_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (pos_w > cnt_w) rsp_d.status = ST_RANGE;
              else if (full) rsp_d.status = ST_FULL;
              else begin
                ctl_d.cop = COP_INSERT;
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (pos_w >= cnt_w) rsp_d.status = ST_RANGE;
              else begin
                ctl_d.cop = COP_REMOVE;
                count_d   = count_q - CNT_W'(1);
              end
            end
            OP_OVERWRITE: begin
              if (pos_w >= cnt_w) rsp_d.status = ST_RANGE;
              else ctl_d.cop = COP_WRITE;
            end
            OP_READ: begin
              if (pos_w >= cnt_w) rsp_d.status = ST_RANGE;
              else begin
                ctl_d.find = 1'b0;
                done_d     = 1'b0;
                state_d    = S_SWEEP;
                sw_cnt_d   = CNT_W'(DEPTH);
              end
            end
            OP_FIND: begin
              ctl_d.find = 1'b1;
              done_d     = 1'b0;
              state_d    = S_SWEEP;
              sw_cnt_d   = CNT_W'(DEPTH);
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              count_d = count_q;
            end
          endcase
          rsp_d.item_count = 7'(count_d);
        end
      end
      S_SWEEP: begin
        if (sw_cnt_q == '0) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          rsp_d   = '{status: ST_OK, found_position: '0, read_value: '0,
                      item_count: 7'(count_q)};
          if (ctl_q.find) begin
            if (hit[DEPTH-1]) rsp_d.found_position = 6'(hit_idx[DEPTH-1]);
            else rsp_d.status = ST_NOTFOUND;
          end else begin
            rsp_d.read_value = 32'(hit_data[DEPTH-1]);
          end
        end else begin
          sw_cnt_d = sw_cnt_q - CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sw_cnt_q <= '0;
      count_q  <= '0;
      limit_q  <= LIMIT_RST;
      ctl_q    <= '{cop: COP_NONE, find: 1'b0};
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sw_cnt_q <= sw_cnt_d;
      count_q  <= count_d;
      ctl_q    <= ctl_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    rsp_q <= rsp_d;
    if (accept) qcnt_q <= count_q;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_BITS-1:0] lower, upper;
    logic                 c_hit;
    logic [IDX_W-1:0]     c_idx;
    logic [ITEM_BITS-1:0] c_data;

    if (i == 0) begin : g_first
      assign lower  = '0;
      assign c_hit  = 1'b0;
      assign c_idx  = '0;
      assign c_data = '0;
    end else begin : g_next
      assign lower  = entry[i-1];
      assign c_hit  = hit[i-1];
      assign c_idx  = hit_idx[i-1];
      assign c_data = hit_data[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = entry[i+1];
    end

    boa_cell #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .ctl_i      (ctl_q),
      .pos_i      (pos_q),
      .count_i    (qcnt_q),
      .value_i    (val_q),
      .lower_i    (lower),
      .upper_i    (upper),
      .entry_o    (entry[i]),
      .hit_i      (c_hit),
      .hit_idx_i  (c_idx),
      .hit_data_i (c_data),
      .hit_o      (hit[i]),
      .hit_idx_o  (hit_idx[i]),
      .hit_data_o (hit_data[i])
    );
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("item count exceeds depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sweep in progress");

  a_find_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.opcode == OP_FIND) |=> busy)
    else $error("find did not start a sweep");

  a_append_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.opcode == OP_APPEND) |=> (done_o && !busy))
    else $error("append result missing");

  a_no_shift_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> (ctl_q.cop == COP_NONE))
    else $error("cell update during sweep");
`endif

endmodule
